// File: rtl/ordered_array_list_engine_macros.svh
// Assertion macros shared by the list engine modules.
`ifndef ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define OALE_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication.
`define OALE_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define OALE_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define OALE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// File: rtl/oale_pkg.sv
package oale_pkg;

  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch;
    logic    load;
    logic    step;
    logic    place;
    logic    res_we;
    status_t res_status;
    logic    res_take_pos;
    logic    res_take_data;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_gt;
    logic pos_ge;
    logic rem_zero;
    logic pend;
    logic match;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/oale_in_if.sv
interface oale_in_if;
  import oale_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

// File: rtl/oale_out_if.sv
interface oale_out_if;
  import oale_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [POS_W-1:0]        found_position;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        length;

  modport source (output valid, output status, output found_position, output read_value,
                  output length, input ready);
  modport sink   (input valid, input status, input found_position, input read_value,
                  input length, output ready);
endinterface

// File: rtl/oale_ctrl.sv
`include "ordered_array_list_engine_macros.svh"

module oale_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  oale_pkg::sts_t  sts,
  output oale_pkg::cmd_t  cmd
);
  import oale_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  logic    err;
  status_t err_code;

  assign in_ready = (state_r == S_IDLE);

  // Precheck of the latched request
  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    case (sts.op)
      OP_INSERT: begin
        if (sts.full) begin
          err      = 1'b1;
          err_code = ST_FULL;
        end else if (sts.pos_gt) begin
          err      = 1'b1;
          err_code = ST_BAD_POS;
        end
      end
      OP_DELETE: begin
        if (sts.empty) begin
          err      = 1'b1;
          err_code = ST_EMPTY;
        end else if (sts.pos_ge) begin
          err      = 1'b1;
          err_code = ST_BAD_POS;
        end
      end
      OP_FIND: begin
        err = 1'b0;
      end
      default: begin
        if (sts.pos_ge) begin
          err      = 1'b1;
          err_code = ST_BAD_POS;
        end
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (err) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = err_code;
          state_nxt      = S_RESULT;
        end else begin
          cmd.load  = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.step = 1'b1;
        if (sts.op == OP_FIND && sts.pend && sts.match) begin
          cmd.res_we       = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_take_pos = 1'b1;
          state_nxt        = S_RESULT;
        end else if (sts.rem_zero) begin
          case (sts.op)
            OP_INSERT: begin
              state_nxt = S_PLACE;
            end
            OP_DELETE: begin
              cmd.cnt_dec    = 1'b1;
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_OK;
              state_nxt      = S_RESULT;
            end
            OP_FIND: begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_NOT_FOUND;
              state_nxt      = S_RESULT;
            end
            default: begin
              cmd.res_we        = 1'b1;
              cmd.res_status    = ST_OK;
              cmd.res_take_data = 1'b1;
              state_nxt         = S_RESULT;
            end
          endcase
        end
      end
      S_PLACE: begin
        cmd.place      = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `OALE_ASSERT_IMPLY(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
  `OALE_ASSERT_IMPLY(a_place_only_insert, clk, rst_n, cmd.place, sts.op == OP_INSERT)
  `OALE_ASSERT_IMPLY(a_dec_only_delete, clk, rst_n, cmd.cnt_dec, sts.op == OP_DELETE)
  `OALE_ASSERT_NEXT(a_place_then_result, clk, rst_n, cmd.place, state_r == S_RESULT)

endmodule

// File: rtl/oale_dpath.sv
`include "ordered_array_list_engine_macros.svh"

module oale_dpath #(
  parameter int CAPACITY = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  oale_pkg::cmd_t                    cmd,
  output oale_pkg::sts_t                    sts,
  input  logic [oale_pkg::OP_W-1:0]         in_opcode,
  input  logic [oale_pkg::POS_W-1:0]        in_position,
  input  logic signed [oale_pkg::VAL_W-1:0] in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [oale_pkg::STAT_W-1:0]       out_status,
  output logic [oale_pkg::POS_W-1:0]        out_found_position,
  output logic signed [oale_pkg::VAL_W-1:0] out_read_value,
  output logic [oale_pkg::LEN_W-1:0]        out_length
);
  import oale_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  // Entry store: one write and one registered read per cycle
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    ra_r, ra_nxt;
  logic [AW-1:0]    wa_r, wa_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic             pend_r, pend_nxt;

  status_t          res_status_r;
  logic [POS_W-1:0] res_pos_r;
  logic [VAL_W-1:0] res_data_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [POS_W-1:0] out_pos_r;
  logic [VAL_W-1:0] out_data_r;
  logic [LEN_W-1:0] out_len_r;

  logic [XW-1:0]    pos_x, cnt_x;
  logic             dir_up;
  logic             rd_en;
  logic             mem_we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             is_shift;

  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(count_r);
  assign dir_up   = (op_r != OP_INSERT);
  assign is_shift = (op_r == OP_INSERT) || (op_r == OP_DELETE);

  assign rd_en  = cmd.step && (rem_r != '0);
  assign mem_we = (cmd.step && pend_r && is_shift) || cmd.place;
  assign waddr  = cmd.place ? AW'(pos_x) : wa_r;
  assign wdata  = cmd.place ? val_r : rdata_r;

  assign sts.op       = op_r;
  assign sts.full     = (count_r == CW'(CAPACITY));
  assign sts.empty    = (count_r == '0);
  assign sts.pos_gt   = (pos_x > cnt_x);
  assign sts.pos_ge   = (pos_x >= cnt_x);
  assign sts.rem_zero = (rem_r == '0);
  assign sts.pend     = pend_r;
  assign sts.match    = (rdata_r == val_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // Sweep setup and advance
  always_comb begin
    ra_nxt   = ra_r;
    wa_nxt   = wa_r;
    rem_nxt  = rem_r;
    pend_nxt = pend_r;
    if (cmd.load) begin
      pend_nxt = 1'b0;
      case (op_r)
        OP_INSERT: begin
          ra_nxt  = AW'(cnt_x - XW'(1));
          wa_nxt  = AW'(count_r);
          rem_nxt = CW'(cnt_x - pos_x);
        end
        OP_DELETE: begin
          ra_nxt  = AW'(pos_x + XW'(1));
          wa_nxt  = AW'(pos_x);
          rem_nxt = CW'(cnt_x - pos_x - XW'(1));
        end
        OP_FIND: begin
          ra_nxt  = '0;
          wa_nxt  = '0;
          rem_nxt = count_r;
        end
        default: begin
          ra_nxt  = AW'(pos_x);
          wa_nxt  = '0;
          rem_nxt = CW'(1);
        end
      endcase
    end else if (cmd.step) begin
      pend_nxt = rd_en;
      if (rd_en) begin
        ra_nxt  = dir_up ? ra_r + AW'(1) : ra_r - AW'(1);
        rem_nxt = rem_r - CW'(1);
      end
      if (pend_r) begin
        wa_nxt = dir_up ? wa_r + AW'(1) : wa_r - AW'(1);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[ra_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r   <= ra_nxt;
    wa_r   <= wa_nxt;
    rem_r  <= rem_nxt;
    pend_r <= pend_nxt;
    if (cmd.latch) begin
      op_r  <= op_t'(in_opcode);
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_pos_r    <= cmd.res_take_pos ? POS_W'(wa_r) : '0;
      res_data_r   <= cmd.res_take_data ? rdata_r : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_pos_r    <= res_pos_r;
      out_data_r   <= res_data_r;
      out_len_r    <= LEN_W'(count_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_pos_r;
  assign out_read_value     = out_data_r;
  assign out_length         = out_len_r;

  `OALE_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  `OALE_ASSERT_IMPLY(a_write_in_list, clk, rst_n, mem_we, CW'(waddr) <= count_r)
  `OALE_ASSERT_IMPLY(a_dec_not_empty, clk, rst_n, cmd.cnt_dec, count_r != '0)
  `OALE_ASSERT_IMPLY(a_inc_not_full, clk, rst_n, cmd.cnt_inc, count_r < CW'(CAPACITY))

endmodule

// File: rtl/ordered_array_list_engine.sv
// Positional list of signed 32-bit values held in a CAPACITY-deep dual-port
// style memory (one write, one registered read per cycle). Each request brings
// an opcode, a position and a value: insert places the value before the position
// and shifts later entries up, delete removes the entry at the position and
// shifts later entries down, find returns the first position holding the value,
// and read returns the entry at the position. Every request yields exactly one
// result with a status code and the list length after the request. Requests are
// handled one at a time. The time to a result is set by the walk over the
// stored entries, one memory access per cycle: insert and delete walk the
// entries between the position and the end of the list, find walks from the
// start up to the first match or the end, read touches the one entry, and a
// rejected request skips the walk. The next request is taken as soon as the
// previous result sits in the output register, even while it still waits to
// be taken. Entries beyond the length are never read; there is no clearing
// pass after reset.
module ordered_array_list_engine #(
  parameter int CAPACITY = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  oale_in_if.sink           in_ch,
  oale_out_if.source        out_ch
);
  import oale_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // Hold the handshake in the controller; move payload through the datapath.
  assign in_ch.ready = in_ready;

  oale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_ch.opcode),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_status         (out_ch.status),
    .out_found_position (out_ch.found_position),
    .out_read_value     (out_ch.read_value),
    .out_length         (out_ch.length)
  );

endmodule
